FILE: hw/rtl/quasilinear_bvp_tridiagonal_solver_defines.svh
// Assertion macros shared by the solver RTL.
// Depends on nothing; files that assert include it by name.
`ifndef QUASILINEAR_BVP_TRIDIAGONAL_SOLVER_DEFINES_SVH
`define QUASILINEAR_BVP_TRIDIAGONAL_SOLVER_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define QBTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next
`define QBTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/qbts_pkg.sv
// Types, codes and helpers of the quasilinear BVP tridiagonal solver.
// No dependencies.
`timescale 1ns / 1ps

package qbts_pkg;

  // Result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StSat   = 2'd1;
  localparam logic [1:0] StShort = 2'd2;

  // Pass count limits and reset value
  localparam logic [3:0] PassReset = 4'd5;
  localparam logic [3:0] PassMax   = 4'd8;

  typedef struct packed {
    logic signed [31:0] left_point;
    logic signed [31:0] right_point;
    logic        [30:0] step_size;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;
  } qbts_in_t;

  typedef struct packed {
    logic        [2:0]  pass_index;
    logic        [3:0]  node_index;
    logic signed [31:0] node_value;
    logic        [1:0]  status;
    logic               last;
  } qbts_out_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/qbts_div.sv
// Iterative signed divider, two quotient bits per cycle, truncating toward zero.
// Depends on nothing; used by the solver top level.
`timescale 1ns / 1ps

module qbts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [49:0] num_i,
  input  logic signed [32:0] den_i,
  output logic               done_o,
  output logic signed [50:0] quot_o
);

  localparam int NumW  = 50;
  localparam int Steps = NumW / 2;
  localparam int CntW  = $clog2(Steps);

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [32:0]     den_q, rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;

  // Two restoring steps per cycle
  always_comb begin
    logic [33:0] t;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < 2; k++) begin
      t = {rem_d, quo_d[NumW-1]};
      quo_d = {quo_d[NumW-2:0], 1'b0};
      if (t >= {1'b0, den_q}) begin
        t = t - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = t[32:0];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[49] ^ den_i[32];
      quo_q <= num_i[49] ? NumW'(-num_i) : NumW'(num_i);
      den_q <= den_i[32] ? 33'(-den_i) : 33'(den_i);
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

FILE: hw/rtl/quasilinear_bvp_tridiagonal_solver.sv
// Sequence: accept, one division for the interval count, one division and one multiply per
// grid node and a multiply for h*h; then per pass, per interior node, ten arithmetic steps
// (S_N0 to S_N9), two divisions, two back-sweep steps and one emit step, which output stalls
// can hold; a short interval gives a single error item.
// Throughput: one item at a time, in_ready_o stays low until the last result is loaded.
// Reset is asynchronous, active low; it clears control state and sets the pass count (cfg_q) to 5.
`timescale 1ns / 1ps
`include "quasilinear_bvp_tridiagonal_solver_defines.svh"

module quasilinear_bvp_tridiagonal_solver #(
  parameter int MAX_INTERVALS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  qbts_pkg::qbts_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qbts_pkg::qbts_out_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [3:0]          cfg_data_i
);

  localparam int IW = $clog2(MAX_INTERVALS + 1);
  localparam int RW = $clog2(MAX_INTERVALS);

  // Sequencer states
  localparam logic [4:0] S_IDLE = 5'd0,  S_CST = 5'd1,  S_CW  = 5'd2,  S_GRID = 5'd3,
                         S_GW   = 5'd4,  S_GMUL = 5'd5, S_GSET = 5'd6, S_H2  = 5'd7,
                         S_H2W  = 5'd8,  S_N0 = 5'd9,   S_N1  = 5'd10, S_N2  = 5'd11,
                         S_N3   = 5'd12, S_N4 = 5'd13,  S_N5  = 5'd14, S_N6  = 5'd15,
                         S_N7   = 5'd16, S_N8 = 5'd17,  S_N9  = 5'd18, S_RST = 5'd19,
                         S_RW   = 5'd20, S_OST = 5'd21, S_OW  = 5'd22, S_B0  = 5'd23,
                         S_B1   = 5'd24, S_EMIT = 5'd25, S_ERR = 5'd26;

  localparam logic signed [67:0] MinusFour = -68'sd262144;
  localparam logic signed [49:0] RatioNum  = -50'sd8589934592;

  logic [4:0]   state_q;
  logic [3:0]   cfg_q;
  logic [2:0]   p_q, lastp_q;
  logic [IW-1:0] i_q, n_q;
  logic [RW-1:0] ri;
  logic [1:0]   st_q;
  logic         out_valid_q, out_valid_d;
  qbts_pkg::qbts_out_t out_q;

  logic signed [31:0] a_q, u_q, v_q;
  logic        [30:0] h_q;
  logic signed [32:0] diff_q, vmu_q;
  logic        [35:0] ih_q;
  logic        [16:0] frac_q;
  logic signed [31:0] twoh2_q, dfy_q, f_q, diag_q, m3_q, m4_q, rhs_q, den_q, num_q;
  logic signed [31:0] pratio_q, poff_q, next_q;
  logic signed [65:0] prod_q;

  logic signed [31:0] grid_q  [MAX_INTERVALS+1];
  logic signed [31:0] cur_q   [MAX_INTERVALS+1];
  logic signed [31:0] ratio_q [MAX_INTERVALS];
  logic signed [31:0] off_q   [MAX_INTERVALS];

  // Sweep stores index by the low node bits
  assign ri = i_q[RW-1:0];

  // Divider hookup
  logic               div_start, div_done;
  logic signed [49:0] div_num;
  logic signed [32:0] div_den;
  logic signed [50:0] div_quot;

  qbts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Input decode
  logic signed [32:0] in_diff;
  logic               in_short, in_acc, out_free, is_first, is_lastn;
  logic [3:0]         pc_eff;
  assign in_diff  = 33'(in_item_i.right_point) - 33'(in_item_i.left_point);
  assign in_short = (in_item_i.step_size == '0) ||
                    ($signed({in_diff[32], in_diff}) <
                     $signed({2'b00, in_item_i.step_size, 1'b0}));
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_first   = (i_q == IW'(1));
  assign is_lastn   = (i_q == IW'(n_q - 1'b1));
  assign pc_eff     = (cfg_q == '0) ? 4'd1 :
                      ((cfg_q > qbts_pkg::PassMax) ? qbts_pkg::PassMax : cfg_q);

  // Output register loads in the emit states, drains on ready
  assign out_valid_d = (out_free && (state_q == S_EMIT || state_q == S_ERR)) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  // Shared multiplier operand select, product registered every cycle
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] qm, y_rd, x_rd, qdiv_res;
  always_comb begin
    y_rd = cur_q[i_q];
    x_rd = grid_q[i_q];
    unique case (state_q)
      S_GMUL: begin mul_a = vmu_q; mul_b = $signed({16'b0, frac_q}); end
      S_H2:   begin mul_a = $signed({2'b0, h_q}); mul_b = $signed({2'b0, h_q}); end
      S_N0:   begin mul_a = 33'(y_rd); mul_b = 33'(y_rd); end
      S_N1:   begin mul_a = 33'(dfy_q); mul_b = 33'(twoh2_q); end
      S_N2:   begin mul_a = 33'(f_q); mul_b = 33'(twoh2_q); end
      S_N3:   begin mul_a = 33'(dfy_q); mul_b = 33'(y_rd); end
      S_N5:   begin mul_a = 33'(m4_q); mul_b = 33'(twoh2_q); end
      S_B0:   begin mul_a = 33'(ratio_q[ri]); mul_b = 33'(next_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign qm       = qbts_pkg::sat32(68'(prod_q >>> 16));
  assign qdiv_res = (den_q == '0) ? '0 : qbts_pkg::sat32(68'(div_quot));

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_CST: begin
        div_start = 1'b1; div_num = 50'(diff_q); div_den = $signed({2'b0, h_q});
      end
      S_GRID: begin
        div_start = 1'b1; div_num = $signed({2'b0, ih_q[31:0], 16'b0}); div_den = diff_q;
      end
      S_RST: begin
        div_start = 1'b1; div_num = is_lastn ? '0 : RatioNum; div_den = 33'(den_q);
      end
      S_OST: begin
        div_start = 1'b1; div_num = $signed({{2{num_q[31]}}, num_q, 16'b0});
        div_den = 33'(den_q);
      end
      default: ;
    endcase
  end

  // Sequencer and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= qbts_pkg::PassReset;
      out_valid_q <= 1'b0;
      p_q         <= '0;
      i_q         <= '0;
      n_q         <= '0;
      st_q        <= qbts_pkg::StOk;
      lastp_q     <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_data_i;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: if (in_acc) begin
          lastp_q <= 3'(pc_eff - 1'b1);
          p_q     <= '0;
          state_q <= in_short ? S_ERR : S_CST;
        end
        S_CST: begin
          p_q <= '0; st_q <= qbts_pkg::StOk; state_q <= S_CW;
        end
        S_CW: if (div_done) begin
          if (div_quot > 51'(MAX_INTERVALS)) begin
            n_q <= IW'(MAX_INTERVALS); st_q <= qbts_pkg::StSat;
          end else begin
            n_q <= IW'(div_quot);
          end
          i_q <= '0;
          state_q <= S_GRID;
        end
        S_GRID: state_q <= S_GW;
        S_GW:   if (div_done) state_q <= S_GMUL;
        S_GMUL: state_q <= S_GSET;
        S_GSET: begin
          if (i_q == n_q) begin
            state_q <= S_H2;
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_GRID;
          end
        end
        S_H2:  state_q <= S_H2W;
        S_H2W: begin i_q <= IW'(1); p_q <= '0; state_q <= S_N0; end
        S_N0:  state_q <= S_N1;
        S_N1:  state_q <= S_N2;
        S_N2:  state_q <= S_N3;
        S_N3:  state_q <= S_N4;
        S_N4:  state_q <= S_N5;
        S_N5:  state_q <= S_N6;
        S_N6:  state_q <= S_N7;
        S_N7:  state_q <= S_N8;
        S_N8:  state_q <= S_N9;
        S_N9:  state_q <= S_RST;
        S_RST: state_q <= S_RW;
        S_RW:  if (div_done) state_q <= S_OST;
        S_OST: state_q <= S_OW;
        S_OW: if (div_done) begin
          if (is_lastn) begin
            state_q <= S_B0;
          end else begin
            i_q <= i_q + 1'b1; state_q <= S_N0;
          end
        end
        S_B0: state_q <= S_B1;
        S_B1: begin
          if (is_first) begin
            state_q <= S_EMIT;
          end else begin
            i_q <= i_q - 1'b1; state_q <= S_B0;
          end
        end
        S_EMIT: if (out_free) begin
          if (is_lastn) begin
            i_q <= IW'(1);
            if (p_q == lastp_q) begin
              state_q <= S_IDLE;
            end else begin
              p_q <= p_q + 1'b1; state_q <= S_N0;
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_ERR: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers and stores
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: if (in_acc) begin
        a_q    <= in_item_i.left_point;
        h_q    <= in_item_i.step_size;
        u_q    <= in_item_i.left_value;
        v_q    <= in_item_i.right_value;
        diff_q <= in_diff;
      end
      S_CST: begin
        vmu_q <= 33'(v_q) - 33'(u_q);
        ih_q  <= '0;
      end
      S_GRID: grid_q[i_q] <= qbts_pkg::sat32(68'(a_q) + $signed({32'b0, ih_q}));
      S_GW:   if (div_done) frac_q <= div_quot[16:0];
      S_GSET: begin
        cur_q[i_q] <= qbts_pkg::sat32(68'(u_q) + 68'(prod_q >>> 16));
        ih_q <= ih_q + 36'(h_q);
      end
      S_H2W: twoh2_q <= qbts_pkg::sat32(68'(qm) * 68'sd2);
      S_N0:  dfy_q <= qbts_pkg::sat32(68'(y_rd) * 68'sd12);
      S_N1:  f_q <= qbts_pkg::sat32(68'(qm) * 68'sd6 - 68'(x_rd));
      S_N2:  diag_q <= qbts_pkg::sat32(MinusFour - 68'(qm));
      S_N3:  m3_q <= qm;
      S_N4:  m4_q <= qm;
      S_N6:  rhs_q <= qbts_pkg::sat32(68'(m3_q) - 68'(qm));
      S_N7: begin
        if (is_first) begin
          rhs_q <= qbts_pkg::sat32(68'(rhs_q) - 68'(qbts_pkg::sat32(68'(u_q) * 68'sd2)));
          den_q <= diag_q;
        end else begin
          den_q <= qbts_pkg::sat32(68'(diag_q) +
                                   68'(qbts_pkg::sat32(68'(pratio_q) * 68'sd2)));
        end
      end
      S_N8: if (is_lastn) begin
        rhs_q <= qbts_pkg::sat32(68'(rhs_q) - 68'(qbts_pkg::sat32(68'(v_q) * 68'sd2)));
      end
      S_N9: begin
        if (is_first) num_q <= rhs_q;
        else num_q <= qbts_pkg::sat32(68'(rhs_q) -
                                      68'(qbts_pkg::sat32(68'(poff_q) * 68'sd2)));
      end
      S_RW: if (div_done) begin
        ratio_q[ri] <= qdiv_res;
        pratio_q    <= qdiv_res;
      end
      S_OW: if (div_done) begin
        off_q[ri] <= qdiv_res;
        poff_q    <= qdiv_res;
        next_q    <= '0;
      end
      S_B1: begin
        next_q     <= qbts_pkg::sat32(68'(qm) + 68'(off_q[ri]));
        cur_q[i_q] <= qbts_pkg::sat32(68'(qm) + 68'(off_q[ri]));
      end
      S_EMIT: if (out_free) begin
        out_q.pass_index <= p_q;
        out_q.node_index <= 4'(i_q);
        out_q.node_value <= cur_q[i_q];
        out_q.status     <= st_q;
        out_q.last       <= is_lastn && (p_q == lastp_q);
      end
      S_ERR: if (out_free) begin
        out_q.pass_index <= '0;
        out_q.node_index <= '0;
        out_q.node_value <= '0;
        out_q.status     <= qbts_pkg::StShort;
        out_q.last       <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  logic div_wait, node_ok, pass_ok;
  assign div_wait = (state_q == S_CW) || (state_q == S_GW) || (state_q == S_RW) ||
                    (state_q == S_OW);
  assign node_ok  = (out_q.node_index != '0) || (out_q.status == qbts_pkg::StShort);
  assign pass_ok  = (p_q <= lastp_q) || (state_q == S_IDLE);

  `QBTS_ASSERT(a_div_done_wait, !div_done || div_wait, "divider finished outside a wait state")
  `QBTS_ASSERT_NEXT(a_accept_busy, in_acc, state_q != S_IDLE, "accepted item left block idle")
  `QBTS_ASSERT(a_node_nonzero, !out_valid_q || node_ok, "node index zero on a normal result")
  `QBTS_ASSERT(a_pass_bound, pass_ok, "pass counter beyond pass limit")

endmodule
